@@ rtl/sor_pkg.sv @@
// Shared types and constants for the segment offset remapper.
// No dependencies; sor_search and the top level import this package.
package sor_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int POS_W       = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CMD_W       = 2;
   localparam int STAT_W      = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_XLATE  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DOMAIN = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

   typedef struct packed {
      logic [POS_W-1:0] seg_begin;
      logic [POS_W-1:0] seg_end;
      logic [POS_W-1:0] seg_orig;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] hi;
      logic             by_begin;
      logic [POS_W-1:0] pos;
   } srch_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] index;
   } srch_rsp_type;

endpackage

@@ rtl/sor_table_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sor_table_ram #(
   parameter int DATA_W = 96,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sor_search.sv @@
// Binary search unit over the segment table, one probe per cycle.
// Depends on sor_pkg; drives the table RAM read port while busy.
module sor_search (
   input  logic                  clock,
   input  logic                  reset,
   input  sor_pkg::srch_req_type req,
   input  sor_pkg::entry_type    rd_data,
   output sor_pkg::rd_req_type   rd,
   output sor_pkg::srch_rsp_type rsp
);
   import sor_pkg::*;

   logic             busy_ff, busy_in;
   logic             pend_ff, pend_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] index_ff, index_in;
   logic             by_begin_ff, by_begin_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic [POS_W-1:0] key;
   logic             go_right;
   logic [CNT_W-1:0] lo_step;
   logic [CNT_W-1:0] hi_step;
   logic [CNT_W:0]   mid_sum;

   // With begins the search finds the first entry above pos, with ends the
   // first entry at or above pos. Either result lands in lo when lo meets hi.
   always_comb begin
      key      = by_begin_ff ? rd_data.seg_begin : rd_data.seg_end;
      go_right = by_begin_ff ? (key <= pos_ff) : (key < pos_ff);
      lo_step  = lo_ff;
      hi_step  = hi_ff;
      if (pend_ff) begin
         if (go_right) begin
            lo_step = mid_ff + CNT_W'(1);
         end else begin
            hi_step = mid_ff;
         end
      end
      mid_sum = {1'b0, lo_step} + {1'b0, hi_step};

      busy_in     = busy_ff;
      pend_in     = pend_ff;
      done_in     = 1'b0;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      index_in    = index_ff;
      by_begin_in = by_begin_ff;
      pos_in      = pos_ff;

      if (req.start) begin
         busy_in     = 1'b1;
         pend_in     = 1'b0;
         lo_in       = req.lo;
         hi_in       = req.hi;
         by_begin_in = req.by_begin;
         pos_in      = req.pos;
      end else if (busy_ff) begin
         if (lo_step < hi_step) begin
            lo_in   = lo_step;
            hi_in   = hi_step;
            mid_in  = mid_sum[CNT_W:1];
            pend_in = 1'b1;
         end else begin
            busy_in  = 1'b0;
            pend_in  = 1'b0;
            done_in  = 1'b1;
            index_in = lo_step;
         end
      end

      rd.en   = busy_ff && (lo_step < hi_step);
      rd.addr = mid_sum[IDX_W:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      index_ff    <= index_in;
      by_begin_ff <= by_begin_in;
      pos_ff      <= pos_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.index = index_ff;

endmodule

@@ rtl/segment_offset_remapper.sv @@
// Segment offset remapper: top level with the command sequencer.
// Depends on sor_pkg, sor_table_ram and sor_search.
//
// The block keeps a sorted table of up to TABLE_DEPTH segments, each a
// (begin, end, original begin) triple, in one synchronous RAM, and maps
// positions of a split text back onto the original text. One item is worked
// on at a time. An append item makes one RAM read of the previous entry, if
// there is one, then the write. A translate item runs binary searches on the
// single RAM read port, one probe per cycle; a search over n entries makes
// at most floor(log2(n)) + 1 probes. An empty span runs one search and a
// non-empty span two; entries they find in range are then read and checked.
// The result sits in an output register, so the next item is accepted while
// the previous result still waits to be taken. The table contents need no
// clearing pass: only entries below the fill count are ever read.
module segment_offset_remapper (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sor_pkg::CMD_W-1:0]   req_cmd,
   input  logic [sor_pkg::POS_W-1:0]   req_span_begin,
   input  logic [sor_pkg::POS_W-1:0]   req_span_end,
   input  logic [sor_pkg::POS_W-1:0]   req_entry_begin,
   input  logic [sor_pkg::POS_W-1:0]   req_entry_end,
   input  logic [sor_pkg::POS_W-1:0]   req_entry_orig_begin,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sor_pkg::POS_W-1:0]   rsp_mapped_begin,
   output logic [sor_pkg::POS_W-1:0]   rsp_mapped_end,
   output logic [sor_pkg::STAT_W-1:0]  rsp_status,
   output logic [sor_pkg::CNT_W-1:0]   rsp_entries_loaded
);
   import sor_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
   localparam logic [ST_W-1:0] ST_DECODE    = 4'd1;
   localparam logic [ST_W-1:0] ST_APP_WR    = 4'd2;
   localparam logic [ST_W-1:0] ST_EMPTY_S   = 4'd3;
   localparam logic [ST_W-1:0] ST_EMPTY_CHK = 4'd4;
   localparam logic [ST_W-1:0] ST_BEG_S     = 4'd5;
   localparam logic [ST_W-1:0] ST_END_S     = 4'd6;
   localparam logic [ST_W-1:0] ST_MAP_B     = 4'd7;
   localparam logic [ST_W-1:0] ST_MAP_E     = 4'd8;
   localparam logic [ST_W-1:0] ST_RESP      = 4'd9;

   // Control state.
   logic [ST_W-1:0]   state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  region_ff, region_in;
   logic              bad_ff, bad_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Item and work registers.
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [POS_W-1:0]  sb_ff, sb_in;
   logic [POS_W-1:0]  se_ff, se_in;
   entry_type         ent_ff, ent_in;
   logic [CNT_W-1:0]  ub_ff, ub_in;
   logic [CNT_W-1:0]  ie_ff, ie_in;
   logic [POS_W-1:0]  mb_ff, mb_in;
   logic [POS_W-1:0]  me_ff, me_in;
   logic              ok_ff, ok_in;
   logic [STAT_W-1:0] status_ff, status_in;

   // Result register.
   logic [POS_W-1:0]  rsp_mb_ff, rsp_mb_in;
   logic [POS_W-1:0]  rsp_me_ff, rsp_me_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // Table RAM and search unit wiring.
   rd_req_type        top_rd;
   rd_req_type        srch_rd;
   rd_req_type        ram_rd;
   entry_type         rd_entry;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   srch_req_type      srch_req;
   srch_rsp_type      srch_rsp;

   logic              accept;
   logic              app_bad;
   logic [POS_W-1:0]  prev_orig_end;
   logic [POS_W-1:0]  remap_sb;
   logic [POS_W-1:0]  remap_se;
   logic              inside_sb;
   logic              inside_se;
   logic [CNT_W-1:0]  region_lo;

   sor_table_ram #(
      .DATA_W ($bits(entry_type)),
      .DEPTH  (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ent_ff),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (rd_entry)
   );

   sor_search u_search (
      .clock   (clock),
      .reset   (reset),
      .req     (srch_req),
      .rd_data (rd_entry),
      .rd      (srch_rd),
      .rsp     (srch_rsp)
   );

   // The sequencer never reads while the search unit is busy, so the read
   // port simply goes to whichever side is asking.
   assign ram_rd = srch_rd.en ? srch_rd : top_rd;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Checks and remaps on the entry that the RAM presents this cycle.
   // The original end of the previous entry wraps like all position math.
   always_comb begin
      prev_orig_end = rd_entry.seg_orig + rd_entry.seg_end - rd_entry.seg_begin;
      remap_sb      = rd_entry.seg_orig + (sb_ff - rd_entry.seg_begin);
      remap_se      = rd_entry.seg_orig + (se_ff - rd_entry.seg_begin);
      inside_sb     = (rd_entry.seg_begin <= sb_ff) && (sb_ff <= rd_entry.seg_end);
      inside_se     = (rd_entry.seg_begin <= se_ff) && (se_ff <= rd_entry.seg_end);
      app_bad       = bad_ff || (ent_ff.seg_begin > ent_ff.seg_end) ||
                      ((count_ff != '0) &&
                       ((rd_entry.seg_end > ent_ff.seg_begin) ||
                        (prev_orig_end > ent_ff.seg_orig)));
      // Only the start of the remembered region matters: ends are sorted in
      // a good table, so the first fit from the region start onward is the
      // same whether or not the search is first held to the region end.
      region_lo     = (region_ff > count_ff) ? count_ff : region_ff;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      region_in     = region_ff;
      bad_in        = bad_ff;
      cmd_in        = cmd_ff;
      sb_in         = sb_ff;
      se_in         = se_ff;
      ent_in        = ent_ff;
      ub_in         = ub_ff;
      ie_in         = ie_ff;
      mb_in         = mb_ff;
      me_in         = me_ff;
      ok_in         = ok_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_mb_in     = rsp_mb_ff;
      rsp_me_in     = rsp_me_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      top_rd        = '0;
      srch_req      = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in           = req_cmd;
               sb_in            = req_span_begin;
               se_in            = req_span_end;
               ent_in.seg_begin = req_entry_begin;
               ent_in.seg_end   = req_entry_end;
               ent_in.seg_orig  = req_entry_orig_begin;
               state_in         = ST_DECODE;
            end
         end

         ST_DECODE: begin
            mb_in     = '0;
            me_in     = '0;
            status_in = STAT_OK;
            case (cmd_ff)
               CMD_CLEAR: begin
                  count_in  = '0;
                  region_in = '0;
                  bad_in    = 1'b0;
                  state_in  = ST_RESP;
               end
               CMD_APPEND: begin
                  if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     status_in = STAT_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     // Fetch the previous entry for the ordering check.
                     top_rd.en   = (count_ff != '0);
                     top_rd.addr = IDX_W'(count_ff - CNT_W'(1));
                     state_in    = ST_APP_WR;
                  end
               end
               CMD_XLATE: begin
                  if (bad_ff) begin
                     status_in = STAT_BAD;
                     state_in  = ST_RESP;
                  end else if (sb_ff == se_ff) begin
                     srch_req.start    = 1'b1;
                     srch_req.lo       = region_lo;
                     srch_req.hi       = count_ff;
                     srch_req.by_begin = 1'b0;
                     srch_req.pos      = se_ff;
                     state_in          = ST_EMPTY_S;
                  end else begin
                     srch_req.start    = 1'b1;
                     srch_req.lo       = '0;
                     srch_req.hi       = count_ff;
                     srch_req.by_begin = 1'b1;
                     srch_req.pos      = sb_ff;
                     state_in          = ST_BEG_S;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_APP_WR: begin
            ram_wr_en = 1'b1;
            bad_in    = app_bad;
            count_in  = count_ff + CNT_W'(1);
            region_in = '0;
            status_in = app_bad ? STAT_BAD : STAT_OK;
            state_in  = ST_RESP;
         end

         ST_EMPTY_S: begin
            if (srch_rsp.done) begin
               ie_in = srch_rsp.index;
               if (srch_rsp.index >= count_ff) begin
                  status_in = STAT_DOMAIN;
                  state_in  = ST_RESP;
               end else begin
                  top_rd.en   = 1'b1;
                  top_rd.addr = srch_rsp.index[IDX_W-1:0];
                  state_in    = ST_EMPTY_CHK;
               end
            end
         end

         ST_EMPTY_CHK: begin
            if (inside_se) begin
               mb_in     = remap_se;
               me_in     = remap_se;
               region_in = ie_ff;
            end else begin
               status_in = STAT_DOMAIN;
            end
            state_in = ST_RESP;
         end

         ST_BEG_S: begin
            if (srch_rsp.done) begin
               // First entry whose begin lies above the span begin.
               ub_in             = srch_rsp.index;
               srch_req.start    = 1'b1;
               srch_req.lo       = '0;
               srch_req.hi       = count_ff;
               srch_req.by_begin = 1'b0;
               srch_req.pos      = se_ff;
               state_in          = ST_END_S;
            end
         end

         ST_END_S: begin
            if (srch_rsp.done) begin
               ie_in = srch_rsp.index;
               if ((ub_ff == '0) || (srch_rsp.index >= count_ff)) begin
                  status_in = STAT_DOMAIN;
                  state_in  = ST_RESP;
               end else begin
                  top_rd.en   = 1'b1;
                  top_rd.addr = IDX_W'(ub_ff - CNT_W'(1));
                  state_in    = ST_MAP_B;
               end
            end
         end

         ST_MAP_B: begin
            ok_in       = inside_sb;
            mb_in       = remap_sb;
            top_rd.en   = 1'b1;
            top_rd.addr = ie_ff[IDX_W-1:0];
            state_in    = ST_MAP_E;
         end

         ST_MAP_E: begin
            if (ok_ff && inside_se) begin
               me_in     = remap_se;
               region_in = ub_ff - CNT_W'(1);
            end else begin
               mb_in     = '0;
               status_in = STAT_DOMAIN;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // Wait only if the previous result is still held.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_mb_in     = mb_ff;
               rsp_me_in     = me_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         region_ff    <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         region_ff    <= region_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sb_ff         <= sb_in;
      se_ff         <= se_in;
      ent_ff        <= ent_in;
      ub_ff         <= ub_in;
      ie_ff         <= ie_in;
      mb_ff         <= mb_in;
      me_ff         <= me_in;
      ok_ff         <= ok_in;
      status_ff     <= status_in;
      rsp_mb_ff     <= rsp_mb_in;
      rsp_me_ff     <= rsp_me_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mapped_begin   = rsp_mb_ff;
   assign rsp_mapped_end     = rsp_me_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entries_loaded = rsp_count_ff;

   // A failed translate item never carries mapped positions.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK) && (cmd_ff == CMD_XLATE))
      |-> ((rsp_mb_ff == '0) && (rsp_me_ff == '0)))
      else $error("mapped positions on a failed translate");

   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table size");

   // The remembered region start never lies beyond the fill count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (region_ff <= count_ff))
      else $error("region start beyond entry count");

   // A write goes only to the next free entry of a table that has room.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ((count_ff < CNT_W'(TABLE_DEPTH)) &&
                     (ram_wr_addr == count_ff[IDX_W-1:0])))
      else $error("table write outside the free entry");

   // A result waiting for an empty output register is loaded on the next edge.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESP) && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not loaded into empty output register");

endmodule
